// ===== rtl/atf_pkg.sv =====
// ----------------------------------------------------------------------------
// atf_pkg
// Shared widths, constants and the CORDIC arctangent table for the
// accelerometer tilt block.
// ----------------------------------------------------------------------------
package atf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;   // square of a 16-bit sample
    localparam int SUM_W    = 32;   // sum of two squares
    localparam int RAD_W    = 48;   // sum with 16 fraction bits
    localparam int ROOT_W   = 24;
    localparam int REM_W    = 27;
    localparam int SQRT_STEPS = 24;
    localparam int NABS_W   = 17;   // |sample|, up to 32768
    localparam int Y0_W     = 25;   // |sample| * 256
    localparam int XY_W     = 27;   // CORDIC datapath, covers the gain
    localparam int ACC_W    = 25;   // angle accumulator, 2^-16 degree
    localparam int ANGLE_W  = 16;
    localparam int LIMIT_W  = 16;

    localparam logic [14:0] RIGHT_ANGLE   = 15'd23040;
    localparam logic [15:0] LIMIT_RESET   = 16'd15;

    // atan(2^-i) in 2^-16 degree, rounded
    function automatic logic [22:0] atan_entry(input logic [4:0] idx);
        logic [22:0] v;
        unique case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/atf_isqrt.sv =====
// ----------------------------------------------------------------------------
// atf_isqrt
// Digit-by-digit integer square root of (sum << 16), one result bit per cycle.
// ----------------------------------------------------------------------------
module atf_isqrt
    import atf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    localparam int CNT_W = $clog2(SQRT_STEPS);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {radicand, 16'h0000};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== rtl/atf_cordic.sv =====
// ----------------------------------------------------------------------------
// atf_cordic
// Vectoring CORDIC, one micro-rotation per cycle; accumulates the angle of
// (x0, y0) in 2^-16 degree.
// ----------------------------------------------------------------------------
module atf_cordic
    import atf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ROOT_W-1:0]       x0,
    input  logic [Y0_W-1:0]         y0,
    output logic signed [ACC_W-1:0] acc,
    output logic                    done
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [XY_W-1:0]  x_sh;
    logic signed [XY_W-1:0]  y_sh;
    logic signed [ACC_W-1:0] ang;

    // arithmetic shift rounds toward minus infinity
    assign x_sh = x_reg >>> cnt_reg;
    assign y_sh = y_reg >>> cnt_reg;
    assign ang  = signed'(ACC_W'(atan_entry(5'(cnt_reg))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= signed'(XY_W'(x0));
            y_reg   <= signed'(XY_W'(y0));
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[XY_W-1])
            begin
                x_reg   <= x_reg + y_sh;
                y_reg   <= y_reg - x_sh;
                acc_reg <= acc_reg + ang;
            end
            else
            begin
                x_reg   <= x_reg - y_sh;
                y_reg   <= y_reg + x_sh;
                acc_reg <= acc_reg - ang;
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/accel_tilt_with_fault_tracking.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_with_fault_tracking
// Sequence: a failed read goes straight to the finish state; a good read first
//   squares the three samples in turn on the shared multiplier, then per angle
//   (roll, then pitch) runs the root and the CORDIC unless a zero input skips them.
// Throughput: one read at a time; in_ready is high only while idle.
// Reset: angles, fail count and fault flag clear, error_limit returns to 15.
// ----------------------------------------------------------------------------
module accel_tilt_with_fault_tracking
    import atf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      read_ok,
    input  logic signed [SAMPLE_W-1:0] accel_x,
    input  logic signed [SAMPLE_W-1:0] accel_y,
    input  logic signed [SAMPLE_W-1:0] accel_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ANGLE_W-1:0] pitch_angle,
    output logic signed [ANGLE_W-1:0] roll_angle,
    output logic                      angles_valid,
    output logic                      sensor_failed
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_ROOT,
        S_ROT,
        S_FIN
    } state_t;

    localparam logic REG_LIMIT = 1'b0;

    state_t                     state_reg;
    logic [1:0]                 mcnt_reg;
    logic                       pass_reg;
    logic [LIMIT_W-1:0]         limit_reg;
    logic [LIMIT_W-1:0]         count_reg;
    logic                       fault_reg;
    logic signed [ANGLE_W-1:0]  pitch_reg;
    logic signed [ANGLE_W-1:0]  roll_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] z_reg;
    logic [SQ_W-1:0]            sqx_reg;
    logic [SQ_W-1:0]            sqy_reg;
    logic [SQ_W-1:0]            sqz_reg;
    logic [NABS_W-1:0]          nabs_reg;
    logic                       neg_reg;
    logic                       ov_reg;
    logic signed [ANGLE_W-1:0]  opitch_reg;
    logic signed [ANGLE_W-1:0]  oroll_reg;
    logic                       ofault_reg;

    logic                       cfg_wr;
    logic                       in_xfer;
    logic [LIMIT_W-1:0]         count_next;
    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [SUM_W-1:0]    mul_prod;
    logic signed [NABS_W-1:0]   num_ext;
    logic [NABS_W-1:0]          num_abs;
    logic                       num_neg;
    logic [SUM_W-1:0]           sum;
    logic                       sqrt_start;
    logic [ROOT_W-1:0]          root;
    logic                       sqrt_done;
    logic                       cordic_start;
    logic signed [ACC_W-1:0]    acc;
    logic                       cordic_done;
    logic [ACC_W-1:0]           acc_pos;
    logic [ACC_W-1:0]           acc_rnd;
    logic [14:0]                mag_deg;
    logic signed [ANGLE_W-1:0]  cordic_angle;
    logic                       fin_load;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_LIMIT) ? 32'(limit_reg) : 32'h0;
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign fin_load = (state_reg == S_FIN) && (!ov_reg || out_ready);

    // failure count, saturating at the error limit
    assign count_next = (count_reg < limit_reg) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:    mul_op = x_reg;
            2'd1:    mul_op = y_reg;
            default: mul_op = z_reg;
        endcase
    end
    assign mul_prod = mul_op * mul_op;

    // roll: atan(y / |(x,z)|); pitch: atan(-x / |(y,z)|)
    always_comb
    begin
        if (!pass_reg)
        begin
            num_ext = NABS_W'(y_reg);
            num_neg = y_reg[SAMPLE_W-1];
            sum     = SUM_W'(sqx_reg) + SUM_W'(sqz_reg);
        end
        else
        begin
            num_ext = NABS_W'(x_reg);
            num_neg = !x_reg[SAMPLE_W-1] && (x_reg != '0);
            sum     = SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        end
        num_abs = num_ext[NABS_W-1] ? NABS_W'(-num_ext) : NABS_W'(num_ext);
    end

    assign sqrt_start   = (state_reg == S_PREP) && (num_abs != '0) && (sum != '0);
    assign cordic_start = (state_reg == S_ROOT) && sqrt_done;

    atf_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum),
        .root     (root),
        .done     (sqrt_done)
    );

    atf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x0    (root),
        .y0    (Y0_W'({nabs_reg, 8'h00})),
        .acc   (acc),
        .done  (cordic_done)
    );

    // clamp at zero, round to 1/256 degree, clamp at 90 degrees, apply sign
    always_comb
    begin
        acc_pos = acc[ACC_W-1] ? '0 : acc;
        acc_rnd = (acc_pos + ACC_W'(128)) >> 8;
        if (acc_rnd > ACC_W'(RIGHT_ANGLE))
            mag_deg = RIGHT_ANGLE;
        else
            mag_deg = acc_rnd[14:0];
        cordic_angle = neg_reg ? -signed'(ANGLE_W'(mag_deg)) : signed'(ANGLE_W'(mag_deg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mcnt_reg   <= '0;
            pass_reg   <= 1'b0;
            limit_reg  <= LIMIT_RESET;
            count_reg  <= '0;
            fault_reg  <= 1'b0;
            pitch_reg  <= '0;
            roll_reg   <= '0;
            ov_reg     <= 1'b0;
            opitch_reg <= '0;
            oroll_reg  <= '0;
            ofault_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_LIMIT))
                limit_reg <= pwdata[LIMIT_W-1:0];

            if (fin_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;

            if (fin_load)
            begin
                opitch_reg <= pitch_reg;
                oroll_reg  <= roll_reg;
                ofault_reg <= fault_reg;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (read_ok)
                        begin
                            count_reg <= '0;
                            fault_reg <= 1'b0;
                            mcnt_reg  <= '0;
                            pass_reg  <= 1'b0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            count_reg <= count_next;
                            if (count_next >= limit_reg)
                                fault_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_MUL:
                begin
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 2'd2)
                        state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    if (sqrt_start)
                        state_reg <= S_ROOT;
                    else
                    begin
                        // zero numerator gives 0, zero magnitude gives +-90 degrees
                        if (!pass_reg)
                        begin
                            roll_reg <= (num_abs == '0) ? '0 :
                                        (num_neg ? -signed'(ANGLE_W'(RIGHT_ANGLE))
                                                 : signed'(ANGLE_W'(RIGHT_ANGLE)));
                            pass_reg <= 1'b1;
                        end
                        else
                        begin
                            pitch_reg <= (num_abs == '0) ? '0 :
                                         (num_neg ? -signed'(ANGLE_W'(RIGHT_ANGLE))
                                                  : signed'(ANGLE_W'(RIGHT_ANGLE)));
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_ROOT:
                begin
                    if (sqrt_done)
                        state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (cordic_done)
                    begin
                        if (!pass_reg)
                        begin
                            roll_reg  <= cordic_angle;
                            pass_reg  <= 1'b1;
                            state_reg <= S_PREP;
                        end
                        else
                        begin
                            pitch_reg <= cordic_angle;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (fin_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg <= accel_x;
            y_reg <= accel_y;
            z_reg <= accel_z;
        end
        if (state_reg == S_MUL)
        begin
            unique case (mcnt_reg)
                2'd0:    sqx_reg <= mul_prod[SQ_W-1:0];
                2'd1:    sqy_reg <= mul_prod[SQ_W-1:0];
                default: sqz_reg <= mul_prod[SQ_W-1:0];
            endcase
        end
        if (sqrt_start)
        begin
            nabs_reg <= num_abs;
            neg_reg  <= num_neg;
        end
    end

    assign out_valid     = ov_reg;
    assign pitch_angle   = opitch_reg;
    assign roll_angle    = oroll_reg;
    assign angles_valid  = !ofault_reg;
    assign sensor_failed = ofault_reg;

endmodule
